@@ sv/assert_macros.svh @@
// Assertion macros used by the verification checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge, ignored while reset is held.
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: property failed");

// Condition that must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("%m: forbidden condition seen");

`endif

@@ sv/psrl_pkg.sv @@
// Types and constants shared by the per-source rate limiter modules.
`timescale 1ns / 1ps

package psrl_pkg;

    localparam int ADDR_W = 64;
    localparam int TIME_W = 64;
    localparam int CNT_W  = 16;

    // Length of one rate window in milliseconds.
    localparam logic [TIME_W-1:0] WINDOW_MS = TIME_W'(60000);
    // Limit in force after reset.
    localparam logic [CNT_W-1:0]  LIMIT_RESET = CNT_W'(30);

    // One table entry as stored in the table memory.
    typedef struct packed {
        logic [ADDR_W-1:0] addr_hi;
        logic [ADDR_W-1:0] addr_lo;
        logic [TIME_W-1:0] win_start;
        logic [TIME_W-1:0] last_seen;
        logic [CNT_W-1:0]  count;
    } t_entry;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic scan;
        logic eval;
        logic write;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_done;
        logic out_free;
    } t_sts;

endpackage

@@ sv/psrl_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps

module psrl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/psrl_dp.sv @@
// Datapath of the rate limiter: table memory, scan, window update and result register.
`timescale 1ns / 1ps

module psrl_dp #(
    parameter int TABLE_ENTRIES = 64
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  psrl_pkg::t_cmd             i_cmd,
    output psrl_pkg::t_sts             o_sts,
    input  logic [psrl_pkg::ADDR_W-1:0] i_addr_hi,
    input  logic [psrl_pkg::ADDR_W-1:0] i_addr_lo,
    input  logic [psrl_pkg::TIME_W-1:0] i_now_ms,
    input  logic                       i_cfg_we,
    input  logic [psrl_pkg::CNT_W-1:0]  i_cfg_data,
    input  logic                       i_out_stall,
    output logic                       o_out_valid,
    output logic                       o_allowed
);

    localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int FW = $clog2(TABLE_ENTRIES + 1);
    localparam logic [FW-1:0] FULL = FW'(TABLE_ENTRIES);

    logic [psrl_pkg::ADDR_W-1:0] r_hi;
    logic [psrl_pkg::ADDR_W-1:0] r_lo;
    logic [psrl_pkg::TIME_W-1:0] r_now;
    logic [psrl_pkg::CNT_W-1:0]  r_limit;
    logic [FW-1:0]               r_fill;
    logic [FW-1:0]               r_rd_idx;
    logic                        r_cmp_vld;
    logic [AW-1:0]               r_cmp_idx;
    logic                        r_hit;
    logic [AW-1:0]               r_hit_idx;
    psrl_pkg::t_entry            r_hit_ent;
    logic                        r_have_old;
    logic [AW-1:0]               r_old_idx;
    logic [psrl_pkg::TIME_W-1:0] r_old_ts;
    logic [AW-1:0]               r_wr_idx;
    psrl_pkg::t_entry            r_wr_ent;
    logic                        r_res_allowed;
    logic                        r_out_vld;
    logic                        r_out_allowed;

    logic [$bits(psrl_pkg::t_entry)-1:0] ram_rdata;
    psrl_pkg::t_entry            rd_ent;
    logic                        more;
    logic                        issue;
    logic                        match;
    logic                        older;

    logic [psrl_pkg::TIME_W-1:0] elapsed;
    logic                        expired;
    logic [psrl_pkg::CNT_W-1:0]  base_cnt;
    logic                        n_allowed;
    psrl_pkg::t_entry            n_wr_ent;
    logic [AW-1:0]               n_wr_idx;

    psrl_ram #(
        .WIDTH ($bits(psrl_pkg::t_entry)),
        .DEPTH (TABLE_ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.write),
        .i_waddr (r_wr_idx),
        .i_wdata (r_wr_ent),
        .i_raddr (r_rd_idx[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    // Scan compare on the entry read in the previous cycle.
    always_comb begin
        rd_ent = psrl_pkg::t_entry'(ram_rdata);
        more   = (r_rd_idx < r_fill);
        issue  = more && !r_hit;
        match  = (rd_ent.addr_hi == r_hi) && (rd_ent.addr_lo == r_lo);
        older  = !r_have_old || (rd_ent.last_seen < r_old_ts);
    end

    // Window update for a hit, or a fresh entry for a miss.
    always_comb begin
        elapsed  = r_now - r_hit_ent.win_start;
        expired  = (elapsed >= psrl_pkg::WINDOW_MS);
        base_cnt = expired ? '0 : r_hit_ent.count;
        n_wr_ent = r_hit_ent;
        if (r_hit) begin
            n_allowed          = (base_cnt < r_limit);
            n_wr_ent.win_start = expired ? r_now : r_hit_ent.win_start;
            n_wr_ent.last_seen = r_now;
            n_wr_ent.count     = n_allowed ? base_cnt + psrl_pkg::CNT_W'(1) : base_cnt;
            n_wr_idx           = r_hit_idx;
        end else begin
            n_allowed          = 1'b1;
            n_wr_ent.addr_hi   = r_hi;
            n_wr_ent.addr_lo   = r_lo;
            n_wr_ent.win_start = r_now;
            n_wr_ent.last_seen = r_now;
            n_wr_ent.count     = psrl_pkg::CNT_W'(1);
            n_wr_idx           = (r_fill < FULL) ? r_fill[AW-1:0] : r_old_idx;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_hi  <= i_addr_hi;
            r_lo  <= i_addr_lo;
            r_now <= i_now_ms;
        end
        if (i_cmd.scan) begin
            r_cmp_idx <= r_rd_idx[AW-1:0];
            if (r_cmp_vld && !r_hit) begin
                if (match) begin
                    r_hit_idx <= r_cmp_idx;
                    r_hit_ent <= rd_ent;
                end else if (older) begin
                    r_old_idx <= r_cmp_idx;
                    r_old_ts  <= rd_ent.last_seen;
                end
            end
        end
        if (i_cmd.eval) begin
            r_wr_idx      <= n_wr_idx;
            r_wr_ent      <= n_wr_ent;
            r_res_allowed <= n_allowed;
        end
        if (i_cmd.write) begin
            r_out_allowed <= r_res_allowed;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit    <= psrl_pkg::LIMIT_RESET;
            r_fill     <= '0;
            r_rd_idx   <= '0;
            r_cmp_vld  <= 1'b0;
            r_hit      <= 1'b0;
            r_have_old <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_limit <= i_cfg_data;
            end
            if (i_cmd.load) begin
                r_rd_idx   <= '0;
                r_cmp_vld  <= 1'b0;
                r_hit      <= 1'b0;
                r_have_old <= 1'b0;
            end else if (i_cmd.scan) begin
                r_cmp_vld <= issue;
                if (issue) begin
                    r_rd_idx <= r_rd_idx + FW'(1);
                end
                if (r_cmp_vld && !r_hit) begin
                    if (match) begin
                        r_hit <= 1'b1;
                    end else if (older) begin
                        r_have_old <= 1'b1;
                    end
                end
            end
            if (i_cmd.write) begin
                r_out_vld <= 1'b1;
                if (!r_hit && (r_fill < FULL)) begin
                    r_fill <= r_fill + FW'(1);
                end
            end else if (r_out_vld && !i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_sts.scan_done = r_hit || (!r_cmp_vld && !more);
    assign o_sts.out_free  = !r_out_vld || !i_out_stall;
    assign o_out_valid     = r_out_vld;
    assign o_allowed       = r_out_allowed;

endmodule

@@ sv/psrl_ctrl.sv @@
// Controller state machine that sequences load, scan, update and write of one request.
`timescale 1ns / 1ps

module psrl_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  psrl_pkg::t_sts i_sts,
    output logic           o_stall,
    output psrl_pkg::t_cmd o_cmd
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_EVAL  = 2'd2;
    localparam logic [1:0] S_WRITE = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_sts.scan_done) begin
                    n_state = S_EVAL;
                end else begin
                    o_cmd.scan = 1'b1;
                end
            end
            S_EVAL: begin
                o_cmd.eval = 1'b1;
                n_state    = S_WRITE;
            end
            S_WRITE: begin
                if (i_sts.out_free) begin
                    o_cmd.write = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_stall = (r_state != S_IDLE);

endmodule

@@ sv/per_source_rate_limiter.sv @@
// Top level of the per-source fixed-window rate limiter.
// Each request transfer carries a 128-bit source address and a millisecond
// timestamp and yields one result transfer with a single allowed bit. Sources
// live in a table of TABLE_ENTRIES entries held in one memory; the table is
// scanned one entry per cycle through the memory's single read port. A
// request is loaded while the block is idle; the scan then reads the filled
// entries in index order, the entry update is registered, and the write step
// stores the entry and loads the result register. A hit ends the scan early.
// A new request can be taken in the cycle its result appears; a stalled
// earlier result stalls the write step. A known source has its 60 second
// window restarted when it has run out, its last-seen time refreshed, and is
// refused once its count has reached the limit. An unknown source takes the
// lowest free entry, or the least recently seen one (lowest index on ties),
// and is always admitted. Entries fill in order and are never freed, so a
// fill count stands in for per-entry valid bits and no clearing pass is
// needed after reset. The limit register resets to 30 and should be written
// only while no request is in flight. The result sits in an output register,
// so a new request transfer is taken while an earlier result waits.
`timescale 1ns / 1ps

module per_source_rate_limiter #(
    parameter int TABLE_ENTRIES = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Request channel.
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [63:0] i_addr_hi,
    input  logic [63:0] i_addr_lo,
    input  logic [63:0] i_now_ms,
    // Result channel.
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_allowed,
    // Limit register write port.
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data
);

    // Commands and status between the controller and the datapath.
    psrl_pkg::t_cmd cmd;
    psrl_pkg::t_sts sts;

    // The controller takes a request only while idle and then steps the
    // datapath through scan, window update and table write.
    psrl_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_sts   (sts),
        .o_stall (o_stall),
        .o_cmd   (cmd)
    );

    // The datapath owns the table memory, the scan state, the limit register
    // and the output register.
    psrl_dp #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_addr_hi   (i_addr_hi),
        .i_addr_lo   (i_addr_lo),
        .i_now_ms    (i_now_ms),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_out_stall (i_stall),
        .o_out_valid (o_valid),
        .o_allowed   (o_allowed)
    );

endmodule

@@ sv/psrl_checker.sv @@
// Port-level checker for the rate limiter and its bind to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module psrl_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic        o_allowed
);

    // A waiting result holds its value until it is taken.
    `ASSERT_CLK(a_out_hold, i_clk, i_rst_n, (o_valid && i_stall) |=> (o_valid && $stable(o_allowed)))

    // After a request transfer the block stays busy through scan and update.
    `ASSERT_CLK(a_busy_after_req, i_clk, i_rst_n, (i_valid && !o_stall) |=> (o_stall ##1 o_stall))

    // A new result only appears at the end of a busy period.
    `ASSERT_CLK(a_result_from_work, i_clk, i_rst_n, $rose(o_valid) |-> $past(o_stall))

    // A result becomes valid only as the block goes back to idle.
    `ASSERT_NEVER(a_no_result_midwork, i_clk, i_rst_n, $rose(o_valid) && o_stall)

endmodule

bind per_source_rate_limiter psrl_checker u_psrl_checker (.*);
